// ===== design/pse_pkg.sv =====
// Shared types and constants for the prime sieve engine.
package pse_pkg;

  // Width of one stored prime and of the limit register.
  localparam int VALUE_W = 12;

  // Lowest limit the sieve will run with, and the limit after reset.
  localparam int LIMIT_FLOOR = 10;
  localparam logic [VALUE_W-1:0] LIMIT_RESET = 12'd100;

  // Codes of the kind field of an input word.
  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  // Top-level sequencer states.
  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_FETCH,
    TOP_BUILD,
    TOP_REPLY
  } top_state_t;

  // Sieve sequencer states.
  typedef enum logic [2:0] {
    SV_IDLE,
    SV_CLEAR,
    SV_OUTER,
    SV_TEST,
    SV_CROSS,
    SV_SCAN,
    SV_DONE
  } sieve_state_t;

  // Status reported by the sieve back to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } sieve_status_t;

endpackage

// ===== design/pse_sieve.sv =====
// Sieve sequencer: composite bitmap memory, crossing-out and prime collection.
module pse_sieve #(
  parameter int MAX_LIMIT   = 4095,
  parameter int PRIME_SLOTS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [$clog2(MAX_LIMIT+1)-1:0]       lim,
  output pse_pkg::sieve_status_t               status,
  output logic                                 list_we,
  output logic [$clog2(PRIME_SLOTS)-1:0]       list_waddr,
  output logic [pse_pkg::VALUE_W-1:0]          list_wdata,
  output logic [$clog2(PRIME_SLOTS+1)-1:0]     count,
  output logic [$clog2(MAX_LIMIT+1)-1:0]       largest
);
  import pse_pkg::*;

  localparam int AW = $clog2(MAX_LIMIT + 1);
  localparam int CW = $clog2(PRIME_SLOTS + 1);
  localparam int LW = $clog2(PRIME_SLOTS);

  // Composite bitmap, one bit per number up to the largest limit.
  logic bitmap [0:MAX_LIMIT];
  logic          bm_we;
  logic [AW-1:0] bm_waddr;
  logic          bm_wdata;
  logic          bm_re;
  logic [AW-1:0] bm_raddr;
  logic          bm_q;

  sieve_state_t  state, state_next;
  logic [AW-1:0] lim_q, lim_q_next;
  logic [AW-1:0] i, i_next;
  logic [AW:0]   sq, sq_next;
  logic [AW:0]   j, j_next;
  logic [AW:0]   k, k_next;
  logic          rd_vld, rd_vld_next;
  logic [AW-1:0] rd_k, rd_k_next;
  logic [CW-1:0] n, n_next;
  logic [AW-1:0] big, big_next;
  logic          sv_done;

  // Bitmap write port and registered read port.
  always_ff @(posedge clk) begin
    if (bm_we) begin
      bitmap[bm_waddr] <= bm_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (bm_re) begin
      bm_q <= bitmap[bm_raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SV_IDLE;
      rd_vld <= 1'b0;
      n      <= '0;
      big    <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_vld_next;
      n      <= n_next;
      big    <= big_next;
    end
  end

  // Working counters and the captured limit.
  always_ff @(posedge clk) begin
    lim_q <= lim_q_next;
    i     <= i_next;
    sq    <= sq_next;
    j     <= j_next;
    k     <= k_next;
    rd_k  <= rd_k_next;
  end

  // Next state: clear the bitmap, cross out multiples, then scan for primes.
  always_comb begin
    state_next  = state;
    lim_q_next  = lim_q;
    i_next      = i;
    sq_next     = sq;
    j_next      = j;
    k_next      = k;
    rd_vld_next = rd_vld;
    rd_k_next   = rd_k;
    n_next      = n;
    big_next    = big;
    bm_we       = 1'b0;
    bm_waddr    = k[AW-1:0];
    bm_wdata    = 1'b0;
    bm_re       = 1'b0;
    bm_raddr    = i;
    list_we     = 1'b0;
    sv_done     = 1'b0;

    unique case (state)
      SV_IDLE: begin
        if (start) begin
          lim_q_next = lim;
          k_next     = '0;
          state_next = SV_CLEAR;
        end
      end

      SV_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = k[AW-1:0];
        bm_wdata = 1'b0;
        if (k[AW-1:0] == lim_q) begin
          i_next     = AW'(2);
          sq_next    = (AW+1)'(4);
          state_next = SV_OUTER;
        end else begin
          k_next = k + 1'b1;
        end
      end

      SV_OUTER: begin
        if (sq > {1'b0, lim_q}) begin
          k_next      = (AW+1)'(2);
          n_next      = '0;
          big_next    = '0;
          rd_vld_next = 1'b0;
          state_next  = SV_SCAN;
        end else begin
          bm_re      = 1'b1;
          bm_raddr   = i;
          state_next = SV_TEST;
        end
      end

      SV_TEST: begin
        if (bm_q) begin
          i_next     = i + 1'b1;
          sq_next    = sq + {i, 1'b1};
          state_next = SV_OUTER;
        end else begin
          j_next     = sq;
          state_next = SV_CROSS;
        end
      end

      SV_CROSS: begin
        if (j > {1'b0, lim_q}) begin
          i_next     = i + 1'b1;
          sq_next    = sq + {i, 1'b1};
          state_next = SV_OUTER;
        end else begin
          bm_we    = 1'b1;
          bm_waddr = j[AW-1:0];
          bm_wdata = 1'b1;
          j_next   = j + {1'b0, i};
        end
      end

      SV_SCAN: begin
        // Result of the read issued in the previous cycle.
        if (rd_vld && !bm_q) begin
          big_next = rd_k;
          if (32'(n) < PRIME_SLOTS) begin
            list_we = 1'b1;
            n_next  = n + 1'b1;
          end
        end
        // Issue the next read, or finish once the last one has drained.
        if (k <= {1'b0, lim_q}) begin
          bm_re       = 1'b1;
          bm_raddr    = k[AW-1:0];
          rd_vld_next = 1'b1;
          rd_k_next   = k[AW-1:0];
          k_next      = k + 1'b1;
        end else begin
          rd_vld_next = 1'b0;
          if (!rd_vld) begin
            state_next = SV_DONE;
          end
        end
      end

      SV_DONE: begin
        sv_done    = 1'b1;
        state_next = SV_IDLE;
      end

      default: begin
        state_next = SV_IDLE;
      end
    endcase
  end

  assign status      = '{busy: (state != SV_IDLE), done: sv_done};
  assign list_waddr  = n[LW-1:0];
  assign list_wdata  = VALUE_W'(rd_k);
  assign count       = n;
  assign largest     = big;

endmodule

// ===== design/prime_sieve_engine_unit.sv =====
// Top level of the prime sieve engine: handshakes, prime list memory and result register.
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+--------------------------------------------------
//  cfg      | cfg_valid/cfg_ready | sieve_limit
//  in       | in_valid/in_stall   | kind, prime_index
//  out      | out_valid/out_stall | prime_count, largest_prime, prime_value, value_valid
//
// A fetch word reads the prime list memory, then loads the result into the output register.
// A build word clears the bitmap up to the saturated limit, crosses out the multiples of each
// trial divisor found unmarked, scans the bitmap for primes and then replies, with at most
// one bitmap access a cycle.
// Reset clears the sequencers and the stored count; no clearing pass is needed.
// A new word is taken while the previous result still waits in the output register.
module prime_sieve_engine_unit #(
  parameter int MAX_LIMIT   = 4095,
  parameter int PRIME_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] sieve_limit,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [9:0]  prime_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] prime_count,
  output logic [11:0] largest_prime,
  output logic [11:0] prime_value,
  output logic        value_valid
);
  import pse_pkg::*;

  localparam int AW = $clog2(MAX_LIMIT + 1);
  localparam int CW = $clog2(PRIME_SLOTS + 1);
  localparam int LW = $clog2(PRIME_SLOTS);

  top_state_t           state, state_next;
  logic [VALUE_W-1:0]   limit_reg;
  logic [AW-1:0]        eff_lim;
  logic [CW-1:0]        stored_count;
  logic [AW-1:0]        stored_largest;
  logic                 fetch_hit, fetch_hit_next;
  logic                 accept;
  logic                 out_free;
  logic                 load_fetch;
  logic                 load_build;
  logic                 start;
  sieve_status_t        status;
  logic                 list_we;
  logic [LW-1:0]        list_waddr;
  logic [VALUE_W-1:0]   list_wdata;
  logic                 list_re;
  logic [VALUE_W-1:0]   list_q;
  logic [CW-1:0]        sv_count;
  logic [AW-1:0]        sv_largest;
  logic [VALUE_W-1:0]   prime_list [0:PRIME_SLOTS-1];

  // Configuration register, always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_reg <= sieve_limit;
    end
  end

  // Saturate the limit to the range the sieve supports.
  always_comb begin
    if (32'(limit_reg) < LIMIT_FLOOR) begin
      eff_lim = AW'(LIMIT_FLOOR);
    end else if (32'(limit_reg) > MAX_LIMIT) begin
      eff_lim = AW'(MAX_LIMIT);
    end else begin
      eff_lim = AW'(limit_reg);
    end
  end

  // Sieve sequencer with its bitmap memory.
  pse_sieve #(
    .MAX_LIMIT   (MAX_LIMIT),
    .PRIME_SLOTS (PRIME_SLOTS)
  ) u_sieve (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .lim        (eff_lim),
    .status     (status),
    .list_we    (list_we),
    .list_waddr (list_waddr),
    .list_wdata (list_wdata),
    .count      (sv_count),
    .largest    (sv_largest)
  );

  // Prime list memory: written by the sieve, read by fetch words.
  always_ff @(posedge clk) begin
    if (list_we) begin
      prime_list[list_waddr] <= list_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (list_re) begin
      list_q <= prime_list[LW'(prime_index)];
    end
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != TOP_IDLE) || status.busy;
  assign out_free = !out_valid || !out_stall;

  // State register and stored build figures.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= TOP_IDLE;
      stored_count   <= '0;
      stored_largest <= '0;
    end else begin
      state <= state_next;
      if (status.done) begin
        stored_count   <= sv_count;
        stored_largest <= sv_largest;
      end
    end
  end

  always_ff @(posedge clk) begin
    fetch_hit <= fetch_hit_next;
  end

  // Next state and control.
  always_comb begin
    state_next     = state;
    fetch_hit_next = fetch_hit;
    start          = 1'b0;
    list_re        = 1'b0;
    load_fetch     = 1'b0;
    load_build     = 1'b0;

    unique case (state)
      TOP_IDLE: begin
        if (accept) begin
          if (kind == KIND_BUILD) begin
            start      = 1'b1;
            state_next = TOP_BUILD;
          end else begin
            list_re        = 1'b1;
            fetch_hit_next = (32'(prime_index) < 32'(stored_count));
            state_next     = TOP_FETCH;
          end
        end
      end

      TOP_FETCH: begin
        if (out_free) begin
          load_fetch = 1'b1;
          state_next = TOP_IDLE;
        end
      end

      TOP_BUILD: begin
        if (status.done) begin
          state_next = TOP_REPLY;
        end
      end

      TOP_REPLY: begin
        if (out_free) begin
          load_build = 1'b1;
          state_next = TOP_IDLE;
        end
      end

      default: begin
        state_next = TOP_IDLE;
      end
    endcase
  end

  // Output register: holds a word until the receiver stops stalling.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_fetch || load_build) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fetch || load_build) begin
      prime_count   <= 11'(stored_count);
      largest_prime <= 12'(stored_largest);
      prime_value   <= (load_fetch && fetch_hit) ? list_q : '0;
      value_valid   <= load_fetch && fetch_hit;
    end
  end

endmodule

// ===== design/pse_checker.sv =====
// Port-level checker for the prime sieve engine, bound to the top level.
module pse_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [10:0] prime_count,
  input logic [11:0] largest_prime,
  input logic [11:0] prime_value,
  input logic        value_valid
);

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(prime_value) &&
      $stable(value_valid) && $stable(prime_count) && $stable(largest_prime))
    else $error("result word changed while stalled");

  // One word at a time: the input stalls right after an accepted word.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted word");

  // A valid fetch returns a real prime from a non-empty list.
  a_valid_fetch: assert property (@(posedge clk) disable iff (rst)
    out_valid && value_valid |-> prime_value >= 12'd2 && prime_count != 11'd0)
    else $error("valid fetch with no prime");

  // Anything but a valid fetch carries a zero value.
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !value_valid |-> prime_value == 12'd0)
    else $error("non-zero value without valid flag");

  // A non-empty list always has a largest prime.
  a_largest: assert property (@(posedge clk) disable iff (rst)
    out_valid && prime_count != 11'd0 |-> largest_prime >= 12'd2)
    else $error("count without largest prime");

endmodule

bind prime_sieve_engine_unit pse_checker u_pse_checker (.*);
